[hw/rtl/adr_pkg.sv]
package adr_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_LD_A,
        ST_CMP,
        ST_MOVE,
        ST_RD_J,
        ST_EMIT_RD,
        ST_EMIT
    } adr_state_t;

    typedef enum logic [1:0] {
        RSEL_I,
        RSEL_J,
        RSEL_J_NEXT,
        RSEL_TAIL
    } adr_rsel_t;

    typedef struct packed {
        logic      load_en;
        logic      i_clr;
        logic      i_inc;
        logic      j_from_i;
        logic      j_inc;
        logic      latch_a;
        logic      move;
        logic      out_load;
        logic      list_clr;
        adr_rsel_t rsel;
    } adr_cmd_t;

    typedef struct packed {
        logic i_done;
        logic j_more;
        logic equal;
        logic out_last;
    } adr_stat_t;

endpackage

[hw/rtl/array_duplicate_remover_top.sv]
// Channel   Handshake          Payload
// input     s_valid/s_ready    s_value[31:0] signed, s_last
// result    m_valid/m_ready    m_value_res[31:0] signed, m_last_res, m_overflow
//
// Loading keeps s_ready high and takes each valid item. After the last item the
// store (one read port, one write port) is scanned one compare per cycle unless a
// removal or row restart holds it; each result is then read and held until m_ready.
// aresetn is synchronous and clears the count, the overflow flag and the controller.
// s_ready is low from the last item until the final result of the list is taken.
module array_duplicate_remover_top
    import adr_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value_res,
    output logic                     m_last_res,
    output logic                     m_overflow
);

    adr_cmd_t  cmd;
    adr_stat_t stat;

    adr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    adr_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .m_value_res (m_value_res),
        .m_last_res  (m_last_res),
        .m_overflow  (m_overflow),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[hw/rtl/adr_ctrl.sv]
module adr_ctrl
    import adr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_last,
    output logic      m_valid,
    input  logic      m_ready,
    input  adr_stat_t stat,
    output adr_cmd_t  cmd
);

    adr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_last) begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I: begin
                state_next = stat.i_done ? ST_EMIT_RD : ST_LD_A;
            end
            ST_LD_A: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                priority if (stat.equal) begin
                    state_next = ST_MOVE;
                end else if (!stat.j_more) begin
                    state_next = ST_RD_I;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_MOVE: begin
                state_next = stat.j_more ? ST_RD_J : ST_RD_I;
            end
            ST_RD_J: begin
                state_next = ST_CMP;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    state_next = stat.out_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.rsel = RSEL_I;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
                cmd.i_clr   = s_valid && s_last;
            end
            ST_RD_I: begin
                cmd.rsel     = RSEL_I;
                cmd.j_from_i = !stat.i_done;
                cmd.i_clr    = stat.i_done;
            end
            ST_LD_A: begin
                cmd.latch_a = 1'b1;
                cmd.rsel    = RSEL_J;
            end
            ST_CMP: begin
                priority if (stat.equal) begin
                    cmd.rsel = RSEL_TAIL;
                end else if (stat.j_more) begin
                    cmd.rsel  = RSEL_J_NEXT;
                    cmd.j_inc = 1'b1;
                end else begin
                    cmd.i_inc = 1'b1;
                end
            end
            ST_MOVE: begin
                cmd.move  = 1'b1;
                cmd.i_inc = !stat.j_more;
            end
            ST_RD_J: begin
                cmd.rsel = RSEL_J;
            end
            ST_EMIT_RD: begin
                cmd.out_load = 1'b1;
            end
            ST_EMIT: begin
                m_valid      = 1'b1;
                cmd.rsel     = RSEL_I;
                cmd.list_clr = m_ready && stat.out_last;
                cmd.i_inc    = m_ready && !stat.out_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/adr_dp.sv]
module adr_dp
    import adr_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [DATA_W-1:0] s_value,
    output logic signed [DATA_W-1:0] m_value_res,
    output logic                     m_last_res,
    output logic                     m_overflow,
    input  adr_cmd_t                 cmd,
    output adr_stat_t                stat
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [DATA_W-1:0] mem [MAX_ELEMENTS];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] a_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [IW-1:0]     raddr;
    logic [IW-1:0]     tail;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     i_plus;
    logic [CW-1:0]     j_plus;
    logic              room;
    logic              wr_en;
    logic [IW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;

    assign count_dec = count_reg - CW'(1);
    assign tail      = count_dec[IW-1:0];
    assign i_plus    = CW'(i_reg) + CW'(1);
    assign j_plus    = CW'(j_reg) + CW'(1);
    assign room      = count_reg < CW'(MAX_ELEMENTS);

    assign stat.i_done   = i_plus >= count_reg;
    assign stat.j_more   = j_plus < count_reg;
    assign stat.equal    = a_reg == rdata_reg;
    assign stat.out_last = m_last_res;

    always_comb begin
        unique case (cmd.rsel)
            RSEL_I:      raddr = i_next;
            RSEL_J:      raddr = j_reg;
            RSEL_J_NEXT: raddr = j_plus[IW-1:0];
            RSEL_TAIL:   raddr = tail;
            default:     raddr = i_next;
        endcase
    end

    always_comb begin
        wr_en = 1'b0;
        waddr = count_reg[IW-1:0];
        wdata = s_value;
        if (cmd.load_en && room) begin
            wr_en = 1'b1;
        end else if (cmd.move) begin
            wr_en = 1'b1;
            waddr = j_reg;
            wdata = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load_en) begin
            if (room) begin
                count_next = count_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end else if (cmd.move) begin
            count_next = count_dec;
        end else if (cmd.list_clr) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        priority if (cmd.i_clr) begin
            i_next = '0;
        end else if (cmd.i_inc) begin
            i_next = i_plus[IW-1:0];
        end else begin
            i_next = i_reg;
        end
        priority if (cmd.j_from_i) begin
            j_next = i_plus[IW-1:0];
        end else if (cmd.j_inc) begin
            j_next = j_plus[IW-1:0];
        end else begin
            j_next = j_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_a) begin
            a_reg <= rdata_reg;
        end
        if (cmd.out_load) begin
            m_value_res <= signed'(rdata_reg);
            m_last_res  <= stat.i_done;
            m_overflow  <= ovf_reg;
        end
    end

endmodule
